>>> hw/rtl/sit_pkg.sv
`timescale 1ns / 1ps

package sit_pkg;

    localparam int ELAPSED_BITS = 32;
    localparam int DUR_W        = 32;
    localparam int SCALE_W      = 16;
    localparam int SCALE_FRAC   = 8;
    localparam int CMD_W        = 3;
    localparam int DELTA_W      = 16;
    localparam int FRAC_W       = 16;
    localparam int PROG_W       = FRAC_W + 1;
    localparam int PROD_W       = DELTA_W + SCALE_W;
    localparam int INC_W        = PROD_W - SCALE_FRAC;
    localparam int SUM_W        = ((ELAPSED_BITS > INC_W) ? ELAPSED_BITS : INC_W) + 1;
    localparam int CMP_W        = (ELAPSED_BITS > DUR_W) ? ELAPSED_BITS : DUR_W;
    localparam int MOD_STEPS    = ELAPSED_BITS;
    localparam int PROG_STEPS   = FRAC_W;
    localparam int STEP_MAX     = (MOD_STEPS > PROG_STEPS) ? MOD_STEPS : PROG_STEPS;
    localparam int CNT_W        = $clog2(STEP_MAX + 1);
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = DUR_W;

    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PAUSE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESUME = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_MODE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE = 2'd2;

    localparam logic [SCALE_W-1:0] TIME_SCALE_RST = SCALE_W'(256);
    localparam logic [PROG_W-1:0]  PROGRESS_ONE   = PROG_W'(1) << FRAC_W;

    typedef struct packed {
        logic start;
        logic is_mod;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

>>> hw/rtl/sit_cmd_if.sv
`timescale 1ns / 1ps

interface sit_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [sit_pkg::CMD_W-1:0]   command;
    logic [sit_pkg::DELTA_W-1:0] delta;

    modport source (output valid, output command, output delta, input ready);
    modport sink   (input valid, input command, input delta, output ready);
endinterface

>>> hw/rtl/sit_res_if.sv
`timescale 1ns / 1ps

interface sit_res_if;
    logic                      valid;
    logic                      ready;
    logic [sit_pkg::PROG_W-1:0] progress;
    logic                      finished;
    logic                      running;

    modport source (output valid, output progress, output finished, output running, input ready);
    modport sink   (input valid, input progress, input finished, input running, output ready);
endinterface

>>> hw/rtl/scaled_interval_timer_core.sv
`timescale 1ns / 1ps
// Path to the result register: start, stop, pause, resume, unused codes and stopped ticks go
// to ST_FIN; a running tick goes ST_ADD, ST_CMP, then ST_FIN if it ends a period without a wrap,
// else ST_DIVP for the progress division or ST_DIVM for a loop-mode wrap, then ST_FIN.
// Throughput: one item at a time; the next item is taken in the cycle after the result register
// loads, and the shared restoring divider, one bit per cycle, sets the cost of a tick.
// Reset (synchronous, active low) clears elapsed, progress and flags and loads register defaults.

module scaled_interval_timer_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    sit_cmd_if.sink                       i_cmd,
    sit_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [sit_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sit_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sit_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIVP = 3'd3;
    localparam logic [2:0] ST_DIVM = 3'd4;
    localparam logic [2:0] ST_FIN  = 3'd5;

    logic [2:0]              r_state;
    logic [DUR_W-1:0]        r_duration;
    logic                    r_loop;
    logic [SCALE_W-1:0]      r_scale;
    logic [ELAPSED_BITS-1:0] r_elapsed;
    logic [PROG_W-1:0]       r_progress;
    logic                    r_running;
    logic                    r_done;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_out_valid;
    logic [PROG_W-1:0]       r_out_prog;
    logic                    r_out_fin;
    logic                    r_out_run;

    logic [INC_W-1:0]        w_inc;
    logic [SUM_W-1:0]        n_sum;
    logic [ELAPSED_BITS-1:0] n_elapsed;
    logic                    w_reached;
    logic                    w_dur_zero;
    logic [CMP_W-1:0]        w_rem_ext;

    t_div_req                w_div_req;
    t_div_sts                w_div_sts;
    logic [FRAC_W-1:0]       w_quo;
    logic [DUR_W-1:0]        w_rem;

    assign w_inc      = r_prod[PROD_W-1:SCALE_FRAC];
    assign n_sum      = SUM_W'(r_elapsed) + SUM_W'(w_inc);
    assign n_elapsed  = (|n_sum[SUM_W-1:ELAPSED_BITS]) ? '1 : n_sum[ELAPSED_BITS-1:0];
    assign w_reached  = (CMP_W'(r_elapsed) >= CMP_W'(r_duration));
    assign w_dur_zero = (r_duration == '0);
    assign w_rem_ext  = CMP_W'(w_rem);

    // A zero duration always counts as reached, so the progress division
    // only ever sees a nonzero divisor.
    assign w_div_req.start  = (r_state == ST_CMP) &&
                              (!w_reached || (r_loop && !w_dur_zero));
    assign w_div_req.is_mod = w_reached;

    sit_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_elapsed (r_elapsed),
        .i_divisor (r_duration),
        .o_sts     (w_div_sts),
        .o_quo     (w_quo),
        .o_rem     (w_rem)
    );

    assign i_cmd.ready    = (r_state == ST_IDLE);
    assign o_res.valid    = r_out_valid;
    assign o_res.progress = r_out_prog;
    assign o_res.finished = r_out_fin;
    assign o_res.running  = r_out_run;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_duration  <= '0;
            r_loop      <= 1'b0;
            r_scale     <= TIME_SCALE_RST;
            r_elapsed   <= '0;
            r_progress  <= '0;
            r_running   <= 1'b0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DURATION:   r_duration <= i_cfg_data[DUR_W-1:0];
                    CFG_LOOP_MODE:  r_loop     <= i_cfg_data[0];
                    CFG_TIME_SCALE: r_scale    <= i_cfg_data[SCALE_W-1:0];
                    default:        ;
                endcase
            end

            if ((r_state == ST_FIN) && (!r_out_valid || o_res.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_cmd.valid) begin
                        r_state <= ((i_cmd.command == CMD_TICK) && r_running) ? ST_ADD : ST_FIN;
                        case (i_cmd.command)
                            CMD_TICK:   r_done <= 1'b0;
                            CMD_START: begin
                                r_running <= 1'b1;
                                r_elapsed <= '0;
                            end
                            CMD_STOP: begin
                                r_running <= 1'b0;
                                r_elapsed <= '0;
                            end
                            CMD_PAUSE:  r_running <= 1'b0;
                            CMD_RESUME: r_running <= 1'b1;
                            default:    ;
                        endcase
                    end
                end
                ST_ADD: begin
                    r_elapsed <= n_elapsed;
                    r_state   <= ST_CMP;
                end
                ST_CMP: begin
                    if (w_reached) begin
                        r_done     <= 1'b1;
                        r_progress <= w_dur_zero ? '0 : PROGRESS_ONE;
                        if (r_loop && !w_dur_zero) begin
                            r_state <= ST_DIVM;
                        end else begin
                            r_elapsed <= '0;
                            if (!r_loop) begin
                                r_running <= 1'b0;
                            end
                            r_state <= ST_FIN;
                        end
                    end else begin
                        r_state <= ST_DIVP;
                    end
                end
                ST_DIVP: begin
                    if (w_div_sts.done) begin
                        r_progress <= {1'b0, w_quo};
                        r_state    <= ST_FIN;
                    end
                end
                ST_DIVM: begin
                    if (w_div_sts.done) begin
                        r_elapsed <= w_rem_ext[ELAPSED_BITS-1:0];
                        r_state   <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_IDLE) && i_cmd.valid) begin
            r_prod <= PROD_W'(i_cmd.delta) * PROD_W'(r_scale);
        end
        if ((r_state == ST_FIN) && (!r_out_valid || o_res.ready)) begin
            r_out_prog <= r_progress;
            r_out_fin  <= r_done;
            r_out_run  <= r_running;
        end
    end

`ifndef ASSERT_OFF
    a_progress_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_progress <= PROGRESS_ONE)
        else $error("progress above one");

    a_wrap_below_dur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DIVM) && w_div_sts.done) |=>
            (CMP_W'(r_elapsed) < CMP_W'(r_duration)))
        else $error("wrapped elapsed not below duration");

    a_divp_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_CMP) && !w_reached) |-> !w_dur_zero)
        else $error("progress division with zero duration");

    a_add_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ADD) |-> r_running)
        else $error("elapsed update on a stopped timer");
`endif

endmodule

>>> hw/rtl/sit_div.sv
`timescale 1ns / 1ps

module sit_div (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sit_pkg::t_div_req               i_req,
    input  logic [sit_pkg::ELAPSED_BITS-1:0] i_elapsed,
    input  logic [sit_pkg::DUR_W-1:0]        i_divisor,
    output sit_pkg::t_div_sts               o_sts,
    output logic [sit_pkg::FRAC_W-1:0]       o_quo,
    output logic [sit_pkg::DUR_W-1:0]        o_rem
);
    import sit_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [CNT_W-1:0]        r_cnt;
    logic [DUR_W-1:0]        r_rem;
    logic [ELAPSED_BITS-1:0] r_num;
    logic [FRAC_W-1:0]       r_quo;

    logic [CMP_W-1:0] w_el_ext;
    logic [DUR_W:0]   w_trial;
    logic [DUR_W:0]   w_diff;
    logic             w_ge;

    // One restoring step per cycle: bring down the next dividend bit and
    // subtract the divisor when it fits.
    assign w_el_ext = CMP_W'(i_elapsed);
    assign w_trial  = {r_rem, r_num[ELAPSED_BITS-1]};
    assign w_diff   = w_trial - {1'b0, i_divisor};
    assign w_ge     = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.is_mod ? CNT_W'(MOD_STEPS) : CNT_W'(PROG_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // For progress the remainder starts at elapsed (known below the divisor)
    // and zeros are shifted in; for the wrap it starts at zero and the
    // elapsed count is shifted in.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.is_mod ? '0 : w_el_ext[DUR_W-1:0];
            r_num <= i_req.is_mod ? i_elapsed : '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DUR_W-1:0] : w_trial[DUR_W-1:0];
            r_num <= {r_num[ELAPSED_BITS-2:0], 1'b0};
            r_quo <= {r_quo[FRAC_W-2:0], w_ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;
    assign o_rem      = r_rem;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && (i_divisor != '0)) |-> (r_rem < i_divisor))
        else $error("divider remainder not below divisor");
`endif

endmodule
